>>> rtl/core/dur_pkg.sv
`default_nettype none

package dur_pkg;

  localparam int MAX_CHANNELS     = 2;
  localparam int NUM_CHANNELS_DEF = 2;

  localparam logic [7:0] TX_DONE_RESET = 8'd1;
  localparam logic [7:0] AGE_MAX       = 8'hFF;

  // command register fields
  localparam int         CR_TX_DIS_BIT = 3;
  localparam int         CR_TX_EN_BIT  = 2;
  localparam logic [3:0] CR_CTR_START  = 4'h8;
  localparam logic [3:0] CR_CTR_STOP   = 4'h9;

  // status / interrupt status bits
  localparam logic [7:0] ISR_TXRDY   = 8'h01;
  localparam logic [7:0] ISR_TX_BITS = 8'h03;
  localparam logic [7:0] ISR_CTR     = 8'h10;
  localparam logic [7:0] SR_TXRDY    = 8'h04;
  localparam logic [7:0] SR_TX_BITS  = 8'h0C;
  localparam int         IMR_TXRDY_BIT = 0;
  localparam int         IMR_CTR_BIT   = 4;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e_t;

  typedef enum logic [2:0] {
    REG_MODE    = 3'd0,
    REG_CSR_SR  = 3'd1,
    REG_CMD     = 3'd2,
    REG_HOLD    = 3'd3,
    REG_AUX     = 3'd4,
    REG_IMR_ISR = 3'd5,
    REG_CTPU    = 3'd6,
    REG_CTPL    = 3'd7
  } reg_e_t;

  // request as seen by one channel
  typedef struct packed {
    logic       apply;
    logic       sel;
    cmd_e_t     cmd;
    reg_e_t     rsel;
    logic [7:0] wdata;
  } chan_op_t;

  // per-channel outcome of one request
  typedef struct packed {
    logic [7:0] rd;
    logic       irq_set;
    logic [7:0] tx_out;
  } chan_res_t;

endpackage

`default_nettype wire

>>> rtl/core/dur_channel.sv
`default_nettype none

module dur_channel (
  input  wire              clk,
  input  wire              rst,
  input  wire dur_pkg::chan_op_t op,
  input  wire  [7:0]       tx_done_ticks,
  output dur_pkg::chan_res_t res
);

  // clock select, aux control and the command byte itself are write-only
  // and never affect any output, so they are not stored.
  logic [7:0]  mode_one, mode_one_next;
  logic [7:0]  mode_two, mode_two_next;
  logic        mode_pointer, mode_pointer_next;
  logic [7:0]  tx_hold, tx_hold_next;
  logic [7:0]  int_mask, int_mask_next;
  logic [7:0]  preset_hi, preset_hi_next;
  logic [7:0]  preset_lo, preset_lo_next;
  logic [7:0]  status_reg, status_reg_next;
  logic [7:0]  int_status, int_status_next;
  logic        counter_running, counter_running_next;
  logic [15:0] counter_value, counter_value_next;
  logic [7:0]  tx_out, tx_out_next;
  logic [7:0]  tx_age, tx_age_next;

  always_comb begin
    logic [15:0] dec;
    logic [7:0]  age;
    logic [7:0]  rd;
    logic        irq_set;

    mode_one_next        = mode_one;
    mode_two_next        = mode_two;
    mode_pointer_next    = mode_pointer;
    tx_hold_next         = tx_hold;
    int_mask_next        = int_mask;
    preset_hi_next       = preset_hi;
    preset_lo_next       = preset_lo;
    status_reg_next      = status_reg;
    int_status_next      = int_status;
    counter_running_next = counter_running;
    counter_value_next   = counter_value;
    tx_out_next          = tx_out;
    tx_age_next          = tx_age;
    rd                   = '0;
    irq_set              = 1'b0;
    dec                  = counter_value - 16'd1;
    age                  = (tx_age == dur_pkg::AGE_MAX) ? tx_age : tx_age + 8'd1;

    if (op.apply) begin
      unique case (op.cmd)
        dur_pkg::CMD_READ: begin
          if (op.sel) begin
            unique case (op.rsel)
              dur_pkg::REG_MODE: begin
                if (!mode_pointer) begin
                  rd                = mode_one;
                  mode_pointer_next = 1'b1;
                end else begin
                  rd = mode_two;
                end
              end
              dur_pkg::REG_CSR_SR:  rd = status_reg;
              dur_pkg::REG_IMR_ISR: rd = int_status;
              default:              rd = '0;
            endcase
          end
        end
        dur_pkg::CMD_WRITE: begin
          if (op.sel) begin
            unique case (op.rsel)
              dur_pkg::REG_MODE: begin
                if (!mode_pointer) begin
                  mode_one_next     = op.wdata;
                  mode_pointer_next = 1'b1;
                end else begin
                  mode_two_next = op.wdata;
                end
              end
              dur_pkg::REG_CMD: begin
                if (op.wdata[dur_pkg::CR_TX_DIS_BIT]) begin
                  int_status_next = int_status_next & ~dur_pkg::ISR_TX_BITS;
                  status_reg_next = status_reg_next & ~dur_pkg::SR_TX_BITS;
                end
                if (op.wdata[dur_pkg::CR_TX_EN_BIT]) begin
                  int_status_next = int_status_next | dur_pkg::ISR_TX_BITS;
                  status_reg_next = status_reg_next | dur_pkg::SR_TX_BITS;
                end
                if (op.wdata[7:4] == dur_pkg::CR_CTR_START) begin
                  counter_value_next   = {preset_hi, preset_lo};
                  counter_running_next = 1'b1;
                end else if (op.wdata[7:4] == dur_pkg::CR_CTR_STOP) begin
                  int_status_next      = int_status_next & ~dur_pkg::ISR_CTR;
                  counter_running_next = 1'b0;
                end
              end
              dur_pkg::REG_HOLD: begin
                tx_hold_next    = op.wdata;
                int_status_next = int_status & ~dur_pkg::ISR_TXRDY;
                status_reg_next = status_reg & ~dur_pkg::SR_TXRDY;
                tx_age_next     = '0;
              end
              dur_pkg::REG_IMR_ISR: int_mask_next  = op.wdata;
              dur_pkg::REG_CTPU:    preset_hi_next = op.wdata;
              dur_pkg::REG_CTPL:    preset_lo_next = op.wdata;
              default: ;
            endcase
          end
        end
        dur_pkg::CMD_TICK: begin
          if (counter_running) begin
            if (dec == '0) begin
              counter_value_next = {preset_hi, preset_lo};
              if (int_mask[dur_pkg::IMR_CTR_BIT]) begin
                int_status_next = int_status_next | dur_pkg::ISR_CTR;
              end
            end else begin
              counter_value_next = dec;
            end
          end
          tx_age_next = age;
          // pending TxRDY with its mask bit raises the line instead of
          // completing another transmit
          if (int_status[0] && int_mask[dur_pkg::IMR_TXRDY_BIT]) begin
            irq_set = 1'b1;
          end else if (age >= tx_done_ticks) begin
            int_status_next = int_status_next | dur_pkg::ISR_TXRDY;
            status_reg_next = status_reg | dur_pkg::SR_TXRDY;
            tx_out_next     = tx_hold;
          end
        end
        dur_pkg::CMD_NONE: ;
      endcase
    end

    res.rd      = rd;
    res.irq_set = irq_set;
    res.tx_out  = tx_out_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_one        <= '0;
      mode_two        <= '0;
      mode_pointer    <= 1'b0;
      tx_hold         <= '0;
      int_mask        <= '0;
      preset_hi       <= '0;
      preset_lo       <= '0;
      status_reg      <= '0;
      int_status      <= '0;
      counter_running <= 1'b0;
      counter_value   <= '0;
      tx_out          <= '0;
      tx_age          <= '0;
    end else begin
      mode_one        <= mode_one_next;
      mode_two        <= mode_two_next;
      mode_pointer    <= mode_pointer_next;
      tx_hold         <= tx_hold_next;
      int_mask        <= int_mask_next;
      preset_hi       <= preset_hi_next;
      preset_lo       <= preset_lo_next;
      status_reg      <= status_reg_next;
      int_status      <= int_status_next;
      counter_running <= counter_running_next;
      counter_value   <= counter_value_next;
      tx_out          <= tx_out_next;
      tx_age          <= tx_age_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/dual_uart_register_model_top.sv
// Dual UART register block with per-channel 16-bit counter/timer.
// Request channel: in_valid / in_stall carrying command (read, write, tick,
//   no-op), address (bit 0 channel, bits 3:1 register) and write_data.
//   A request is taken at a rising edge with in_valid high and in_stall low.
// Result channel: out_valid / out_stall carrying read_data, irq and the two
//   transmit output bytes, one result per request, in request order.
// Configuration: cfg_we / cfg_wdata write tx_done_ticks at once; write it
//   only while no request is in flight.
// Path: a request goes through the request register, then the register update
//   and the result register in one pass.
// Throughput: one request per cycle while out_stall is low, set by the single update pass.
// Stall: while out_stall holds a result, one further request is held in the
//   request register and in_stall rises; register state does not move until
//   that request is applied.
// Reset (rst, synchronous): all channel registers to their reset values,
//   command register reads as its reset code only implicitly (not readable),
//   tx_done_ticks to 1, the irq latch cleared, both pipeline stages emptied.
`default_nettype none

module dual_uart_register_model_top #(
  parameter int NUM_CHANNELS = dur_pkg::NUM_CHANNELS_DEF
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [1:0] command,
  input  wire  [3:0] address,
  input  wire  [7:0] write_data,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [7:0] read_data,
  output logic       irq,
  output logic [7:0] tx_byte_a,
  output logic [7:0] tx_byte_b,
  input  wire        cfg_we,
  input  wire  [7:0] cfg_wdata
);

  // request register
  logic       req_valid;
  logic [1:0] req_cmd;
  logic [3:0] req_addr;
  logic [7:0] req_wdata;

  logic [7:0] tx_done_ticks;
  logic       irq_latch;

  logic accept;
  logic advance;

  dur_pkg::chan_res_t ch_res [dur_pkg::MAX_CHANNELS];

  // the request is applied when the result register is free or draining
  assign advance  = req_valid && (!out_valid || !out_stall);
  assign in_stall = req_valid && out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (accept) begin
      req_valid <= 1'b1;
    end else if (advance) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_cmd   <= command;
      req_addr  <= address;
      req_wdata <= write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_done_ticks <= dur_pkg::TX_DONE_RESET;
    end else if (cfg_we) begin
      tx_done_ticks <= cfg_wdata;
    end
  end

  // one channel per address bit 0 value; absent channels ignore accesses
  for (genvar c = 0; c < dur_pkg::MAX_CHANNELS; c++) begin : g_chan
    if (c < NUM_CHANNELS) begin : g_on
      dur_pkg::chan_op_t op;

      always_comb begin
        op.apply = advance;
        op.sel   = (req_addr[0] == 1'(c));
        op.cmd   = dur_pkg::cmd_e_t'(req_cmd);
        op.rsel  = dur_pkg::reg_e_t'(req_addr[3:1]);
        op.wdata = req_wdata;
      end

      dur_channel u_chan (
        .clk           (clk),
        .rst           (rst),
        .op            (op),
        .tx_done_ticks (tx_done_ticks),
        .res           (ch_res[c])
      );
    end else begin : g_off
      assign ch_res[c] = '0;
    end
  end

  logic irq_next;
  logic [7:0] rd_sel;

  always_comb begin
    irq_next = irq_latch;
    if (advance) begin
      for (int c = 0; c < dur_pkg::MAX_CHANNELS; c++) begin
        irq_next = irq_next | ch_res[c].irq_set;
      end
    end
    rd_sel = ch_res[req_addr[0]].rd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      irq_latch <= 1'b0;
    end else begin
      irq_latch <= irq_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      read_data <= rd_sel;
      irq       <= irq_next;
      tx_byte_a <= ch_res[0].tx_out;
      tx_byte_b <= ch_res[1].tx_out;
    end
  end

endmodule

`default_nettype wire

>>> tb/dual_uart_register_model_top_tb.sv
`timescale 1ns / 100ps

module dual_uart_register_model_top_tb;
  import dur_pkg::*;

  // one request as queued for the driver
  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] addr;
    logic [7:0] wdata;
  } bus_req_t;

  // what the block should show for one request
  typedef struct packed {
    logic [7:0] rd;
    logic       irq;
    logic [7:0] tx_a;
    logic [7:0] tx_b;
  } uart_obs_t;

  // ---------------------------------------------------------------------
  // DUT connections: every input has a known value from time zero
  // ---------------------------------------------------------------------
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  wire        in_stall;
  logic [1:0] command = 2'd0;
  logic [3:0] address = 4'd0;
  logic [7:0] write_data = 8'd0;
  wire        out_valid;
  logic       out_stall = 1'b0;
  wire  [7:0] read_data;
  wire        irq;
  wire  [7:0] tx_byte_a;
  wire  [7:0] tx_byte_b;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;

  dual_uart_register_model_top uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .address    (address),
    .write_data (write_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_data  (read_data),
    .irq        (irq),
    .tx_byte_a  (tx_byte_a),
    .tx_byte_b  (tx_byte_b),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Shadow copy of the register file, advanced once per accepted request
  // ---------------------------------------------------------------------
  logic [7:0]  sh_mode1 [MAX_CHANNELS];
  logic [7:0]  sh_mode2 [MAX_CHANNELS];
  logic        sh_ptr   [MAX_CHANNELS];
  logic [7:0]  sh_csr   [MAX_CHANNELS];
  logic [7:0]  sh_cr    [MAX_CHANNELS];
  logic [7:0]  sh_thr   [MAX_CHANNELS];
  logic [7:0]  sh_acr   [MAX_CHANNELS];
  logic [7:0]  sh_imr   [MAX_CHANNELS];
  logic [7:0]  sh_ctpu  [MAX_CHANNELS];
  logic [7:0]  sh_ctpl  [MAX_CHANNELS];
  logic [7:0]  sh_sr    [MAX_CHANNELS];
  logic [7:0]  sh_isr   [MAX_CHANNELS];
  logic        sh_run   [MAX_CHANNELS];
  logic [15:0] sh_ctr   [MAX_CHANNELS];
  logic [7:0]  sh_txo   [MAX_CHANNELS];
  logic [7:0]  sh_age   [MAX_CHANNELS];
  logic        sh_irq;
  logic [7:0]  sh_tx_done;

  bus_req_t  req_backlog [$];   // requests not yet put on the bus
  uart_obs_t due_obs [$];       // predictions waiting for their result
  int        errors = 0;
  int        queued = 0;        // requests queued so far
  logic      quiet = 1'b0;      // no idling on either side when set
  logic      req_taken = 1'b0;  // request accepted at the last rising edge
  int        gap_left = 0;
  int        stall_left = 0;
  bus_req_t  drv_next;
  uart_obs_t mon_want;
  uart_obs_t mon_pred;

  // Apply one request to the shadow registers and give the expected result.
  task automatic step_uart_regs(input bus_req_t r, output uart_obs_t o);
    int         ch;
    reg_e_t     rs;
    logic [7:0] rd;
    logic [7:0] v;
    ch = r.addr[0];
    rs = reg_e_t'(r.addr[3:1]);
    rd = 8'h00;
    v  = r.wdata;
    case (cmd_e_t'(r.cmd))
      CMD_READ: begin
        case (rs)
          REG_MODE: begin
            // first access of the pair goes to mode one and moves the pointer
            if (!sh_ptr[ch]) begin
              rd = sh_mode1[ch];
              sh_ptr[ch] = 1'b1;
            end else begin
              rd = sh_mode2[ch];
            end
          end
          REG_CSR_SR:  rd = sh_sr[ch];
          REG_IMR_ISR: rd = sh_isr[ch];
          default:     rd = 8'h00;
        endcase
      end
      CMD_WRITE: begin
        case (rs)
          REG_MODE: begin
            if (!sh_ptr[ch]) begin
              sh_mode1[ch] = v;
              sh_ptr[ch] = 1'b1;
            end else begin
              sh_mode2[ch] = v;
            end
          end
          REG_CSR_SR: sh_csr[ch] = v;
          REG_CMD: begin
            sh_cr[ch] = v;
            // disable first, enable after, so both bits leave TX enabled
            if (v[CR_TX_DIS_BIT]) begin
              sh_isr[ch] = sh_isr[ch] & ~ISR_TX_BITS;
              sh_sr[ch]  = sh_sr[ch] & ~SR_TX_BITS;
            end
            if (v[CR_TX_EN_BIT]) begin
              sh_isr[ch] = sh_isr[ch] | ISR_TX_BITS;
              sh_sr[ch]  = sh_sr[ch] | SR_TX_BITS;
            end
            if (v[7:4] == CR_CTR_START) begin
              sh_ctr[ch] = {sh_ctpu[ch], sh_ctpl[ch]};
              sh_run[ch] = 1'b1;
            end else if (v[7:4] == CR_CTR_STOP) begin
              sh_isr[ch] = sh_isr[ch] & ~ISR_CTR;
              sh_run[ch] = 1'b0;
            end
          end
          REG_HOLD: begin
            sh_thr[ch] = v;
            sh_isr[ch] = sh_isr[ch] & ~ISR_TXRDY;
            sh_sr[ch]  = sh_sr[ch] & ~SR_TXRDY;
            sh_age[ch] = 8'd0;
          end
          REG_AUX:     sh_acr[ch]  = v;
          REG_IMR_ISR: sh_imr[ch]  = v;
          REG_CTPU:    sh_ctpu[ch] = v;
          default:     sh_ctpl[ch] = v;
        endcase
      end
      CMD_TICK: begin
        for (int c = 0; c < MAX_CHANNELS; c++) begin
          if (sh_run[c]) begin
            sh_ctr[c] = sh_ctr[c] - 16'd1;   // zero preset wraps to 0xFFFF
            if (sh_ctr[c] == 16'd0) begin
              if (sh_imr[c][IMR_CTR_BIT]) sh_isr[c] = sh_isr[c] | ISR_CTR;
              sh_ctr[c] = {sh_ctpu[c], sh_ctpl[c]};
            end
          end
          if (sh_age[c] != AGE_MAX) sh_age[c] = sh_age[c] + 8'd1;
          if (sh_isr[c][0] && sh_imr[c][IMR_TXRDY_BIT]) begin
            sh_irq = 1'b1;
          end else if (sh_age[c] >= sh_tx_done) begin
            sh_isr[c] = sh_isr[c] | ISR_TXRDY;
            sh_sr[c]  = sh_sr[c] | SR_TXRDY;
            sh_txo[c] = sh_thr[c];
          end
        end
      end
      default: ;  // no-op request only reports the outputs
    endcase
    o.rd   = rd;
    o.irq  = sh_irq;
    o.tx_a = sh_txo[0];
    o.tx_b = sh_txo[1];
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("MISMATCH %s: got %02h, expected %02h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // ---------------------------------------------------------------------
  // Monitor and predictor, both on the rising edge. Outputs read here are
  // the values before this edge's updates, inputs were set at the falling
  // edge, so nothing depends on event order.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_obs.size() == 0) begin
          report_mismatch("result with no request due", read_data, 8'h00);
        end else begin
          mon_want = due_obs.pop_front();
          if (read_data !== mon_want.rd)  report_mismatch("read_data", read_data, mon_want.rd);
          if (irq !== mon_want.irq)       report_mismatch("irq", {7'd0, irq}, {7'd0, mon_want.irq});
          if (tx_byte_a !== mon_want.tx_a) report_mismatch("tx_byte_a", tx_byte_a, mon_want.tx_a);
          if (tx_byte_b !== mon_want.tx_b) report_mismatch("tx_byte_b", tx_byte_b, mon_want.tx_b);
        end
      end
      if (cfg_we) sh_tx_done = cfg_wdata;
      req_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        step_uart_regs({command, address, write_data}, mon_pred);
        due_obs.push_back(mon_pred);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Request driver, falling edge. A request is held until taken; gaps only
  // start between requests, and never depend on in_stall.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !req_taken) begin
      // stalled: payload stays put
    end else if (gap_left != 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (req_backlog.size() != 0) begin
      if (!quiet && $urandom_range(0, 11) == 0) begin
        in_valid <= 1'b0;
        gap_left <= $urandom_range(0, 12);   // start a burst of idle cycles
      end else begin
        drv_next   = req_backlog.pop_front();
        in_valid   <= 1'b1;
        command    <= drv_next.cmd;
        address    <= drv_next.addr;
        write_data <= drv_next.wdata;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result back-pressure, in random bursts of stalled cycles
  always @(negedge clk) begin
    if (quiet) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic logic [3:0] reg_addr(input reg_e_t r, input int ch);
    return {r, ch[0]};
  endfunction

  task automatic push_req(input logic [1:0] cmd, input logic [3:0] addr,
                          input logic [7:0] wd);
    bus_req_t r;
    r.cmd   = cmd;
    r.addr  = addr;
    r.wdata = wd;
    req_backlog.push_back(r);
    queued++;
  endtask

  // everything queued has been taken and every result has come back
  task automatic wait_idle;
    while (req_backlog.size() != 0 || in_valid || due_obs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_tx_done(input logic [7:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Some well-formed sequences (counter programming, hold write and wait for
  // TxRDY, a long run of ticks), the rest single requests, some of them random.
  task automatic random_phase(input int n);
    int stop_at;
    int pick;
    int ch;
    int k;
    stop_at = queued + n;
    while (queued < stop_at) begin
      pick = $urandom_range(0, 99);
      ch   = $urandom_range(0, 1);
      if (pick < 15) begin
        // program the counter with a short period, run it, look at ISR
        push_req(CMD_WRITE, reg_addr(REG_CTPU, ch),
                 ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00);
        push_req(CMD_WRITE, reg_addr(REG_CTPL, ch), 8'($urandom_range(0, 6)));
        push_req(CMD_WRITE, reg_addr(REG_IMR_ISR, ch),
                 ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                             : (8'($urandom) | (8'h01 << IMR_CTR_BIT)));
        push_req(CMD_WRITE, reg_addr(REG_CMD, ch), {CR_CTR_START, 4'($urandom)});
        k = $urandom_range(1, 12);
        repeat (k) push_req(CMD_TICK, 4'($urandom), 8'($urandom));
        push_req(CMD_READ, reg_addr(REG_IMR_ISR, ch), 8'($urandom));
        if ($urandom_range(0, 1) == 1)
          push_req(CMD_WRITE, reg_addr(REG_CMD, ch), {CR_CTR_STOP, 4'($urandom)});
      end else if (pick < 30) begin
        // hold write, a few ticks, then status
        push_req(CMD_WRITE, reg_addr(REG_HOLD, ch), 8'($urandom));
        k = $urandom_range(0, 5);
        repeat (k) push_req(CMD_TICK, 4'($urandom), 8'($urandom));
        push_req(CMD_READ, reg_addr(REG_CSR_SR, ch), 8'($urandom));
        push_req(CMD_READ, reg_addr(REG_IMR_ISR, ch), 8'($urandom));
      end else if (pick < 35) begin
        push_req(2'($urandom_range(0, 1)), reg_addr(REG_MODE, ch), 8'($urandom));
      end else if (pick < 45) begin
        push_req(CMD_WRITE, reg_addr(REG_CMD, ch), 8'($urandom));
      end else if (pick < 47) begin
        k = $urandom_range(20, 60);
        repeat (k) push_req(CMD_TICK, 4'($urandom), 8'($urandom));
      end else if (pick < 65) begin
        push_req(CMD_TICK, 4'($urandom), 8'($urandom));
      end else begin
        push_req(2'($urandom), 4'($urandom), 8'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      sh_mode1[c] = 8'h00; sh_mode2[c] = 8'h00; sh_ptr[c] = 1'b0;
      sh_csr[c]   = 8'h00; sh_cr[c]    = 8'h0A; sh_thr[c] = 8'h00;
      sh_acr[c]   = 8'h00; sh_imr[c]   = 8'h00;
      sh_ctpu[c]  = 8'h00; sh_ctpl[c]  = 8'h00;
      sh_sr[c]    = 8'h00; sh_isr[c]   = 8'h00;
      sh_run[c]   = 1'b0;  sh_ctr[c]   = 16'h0000;
      sh_txo[c]   = 8'h00; sh_age[c]   = 8'h00;
    end
    sh_irq     = 1'b0;
    sh_tx_done = TX_DONE_RESET;

    repeat (10) @(negedge clk);
    rst = 1'b0;

    // directed: mode pointer, TX enable/disable, hold, counter, reads of 0
    push_req(CMD_READ,  reg_addr(REG_MODE, 0), 8'h00);   // mode one, pointer moves
    push_req(CMD_WRITE, reg_addr(REG_MODE, 0), 8'hFF);   // now mode two
    push_req(CMD_READ,  reg_addr(REG_MODE, 0), 8'h00);
    push_req(CMD_WRITE, reg_addr(REG_MODE, 1), 8'hA5);   // write moves pointer too
    push_req(CMD_READ,  reg_addr(REG_MODE, 1), 8'hFF);
    push_req(CMD_TICK,  4'h0, 8'h00);
    push_req(CMD_WRITE, reg_addr(REG_HOLD, 0), 8'hFF);
    push_req(CMD_WRITE, reg_addr(REG_HOLD, 1), 8'h5A);
    push_req(CMD_TICK,  4'hF, 8'hFF);
    push_req(CMD_WRITE, reg_addr(REG_CMD, 0), 8'h08);    // TX disable
    push_req(CMD_READ,  reg_addr(REG_CSR_SR, 0), 8'h00);
    push_req(CMD_WRITE, reg_addr(REG_CMD, 0), 8'h0C);    // disable and enable
    push_req(CMD_WRITE, reg_addr(REG_IMR_ISR, 1), 8'h10);
    push_req(CMD_WRITE, reg_addr(REG_CMD, 1), {CR_CTR_START, 4'h0}); // zero preset
    push_req(CMD_TICK,  4'h1, 8'h00);                    // wraps to 0xFFFF
    push_req(CMD_WRITE, reg_addr(REG_CTPL, 0), 8'h01);
    push_req(CMD_WRITE, reg_addr(REG_IMR_ISR, 0), 8'h10);
    push_req(CMD_WRITE, reg_addr(REG_CMD, 0), {CR_CTR_START, 4'h0});
    push_req(CMD_TICK,  4'h0, 8'h00);                    // reaches zero, ISR bit 4
    push_req(CMD_READ,  reg_addr(REG_IMR_ISR, 0), 8'h00);
    push_req(CMD_WRITE, reg_addr(REG_CMD, 0), {CR_CTR_STOP, 4'h0});
    push_req(CMD_NONE,  4'hF, 8'hFF);
    push_req(CMD_WRITE, reg_addr(REG_CSR_SR, 0), 8'hFF);
    push_req(CMD_WRITE, reg_addr(REG_AUX, 1), 8'hFF);
    for (int r = 2; r < 8; r++)
      if (r != 5) push_req(CMD_READ, reg_addr(reg_e_t'(r), 1), 8'h00); // always 0
    push_req(CMD_WRITE, reg_addr(REG_IMR_ISR, 0), 8'h01);
    push_req(CMD_TICK,  4'h0, 8'h00);                    // sticky irq sets
    random_phase(100);
    wait_idle();

    // sweep tx_done_ticks, extremes included
    write_tx_done(8'd0);
    random_phase(150);
    wait_idle();

    write_tx_done(8'd255);
    push_req(CMD_WRITE, reg_addr(REG_HOLD, 0), 8'h3C);
    repeat (256) push_req(CMD_TICK, 4'($urandom), 8'($urandom));
    push_req(CMD_READ, reg_addr(REG_CSR_SR, 0), 8'h00);
    random_phase(150);
    wait_idle();

    write_tx_done(8'($urandom_range(2, 8)));
    random_phase(150);
    wait_idle();

    write_tx_done(8'($urandom));
    random_phase(150);
    wait_idle();

    // last stretch runs at full rate with no idling
    quiet = 1'b1;
    write_tx_done(8'd1);
    random_phase(150);
    wait_idle();
    repeat (10) @(posedge clk);

    if (errors == 0 && due_obs.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> files.f
rtl/core/dur_pkg.sv
rtl/core/dur_channel.sv
rtl/core/dual_uart_register_model_top.sv
tb/dual_uart_register_model_top_tb.sv
